### rtl/sparse_table_range_min_macros.svh
// ----------------------------------------------------------------------------
// Sparse table range minimum: assertion macros
// Shared concurrent assertion forms, clocked on clk_i and held off in reset.
// ----------------------------------------------------------------------------
`ifndef SPARSE_TABLE_RANGE_MIN_MACROS_SVH
`define SPARSE_TABLE_RANGE_MIN_MACROS_SVH

// The condition holds at every clock edge out of reset.
`define STRM_ASSERT_HOLDS(label, cond) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("strm: invariant violated");

// The consequent holds in the cycle after the antecedent.
`define STRM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("strm: sequence violated");

`endif

### rtl/strm_pkg.sv
// ----------------------------------------------------------------------------
// Sparse table range minimum: package
// Item types, codes and default sizes shared by the front, queue and back.
// ----------------------------------------------------------------------------
package strm_pkg;

  localparam int MAX_ELEMENTS_DEF = 1024;
  localparam int LEVELS_DEF       = 11;
  localparam int DATA_WIDTH_DEF   = 32;

  localparam int QUEUE_DEPTH = 2;
  localparam int LENGTH_W    = 11;
  localparam int POS_W       = 11;
  localparam int LVL_W       = 4;

  typedef enum logic [1:0] {
    ACT_LOAD  = 2'd0,
    ACT_BUILD = 2'd1,
    ACT_QUERY = 2'd2,
    ACT_NONE  = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    STS_ANSWER    = 2'd0,
    STS_BUILT     = 2'd1,
    STS_BAD_RANGE = 2'd2,
    STS_NOT_BUILT = 2'd3
  } status_e;

  typedef enum logic {
    CFG_LENGTH = 1'b0,
    CFG_MODE   = 1'b1
  } cfg_index_e;

  typedef enum logic [1:0] {
    CMD_LOAD   = 2'd0,
    CMD_BUILD  = 2'd1,
    CMD_QUERY  = 2'd2,
    CMD_REPORT = 2'd3
  } cmd_e;

  typedef struct packed {
    action_e            action;
    logic [9:0]         index;
    logic signed [31:0] value;
    logic [9:0]         left;
    logic [10:0]        right;
  } strm_in_t;

  typedef struct packed {
    logic signed [31:0] answer;
    status_e            status;
  } strm_out_t;

  // Classified item as it travels from the front to the back.
  typedef struct packed {
    cmd_e               kind;
    status_e            status;
    logic [LVL_W-1:0]   lvl;
    logic [POS_W-1:0]   pos_a;
    logic [POS_W-1:0]   pos_b;
    logic [31:0]        value;
  } cmd_t;

endpackage

### rtl/strm_front.sv
// ----------------------------------------------------------------------------
// Sparse table range minimum: front end
// Accepts items, tracks the built mark and classifies queries into table
// reads or immediate status reports.
// ----------------------------------------------------------------------------
module strm_front import strm_pkg::*; #(
  parameter int  MAX_ELEMENTS = MAX_ELEMENTS_DEF,
  parameter int  LEVELS       = LEVELS_DEF,
  localparam int N_W          = $clog2(MAX_ELEMENTS + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  strm_in_t            in_i,
  input  logic [LENGTH_W-1:0] length_i,
  input  logic                q_full_i,
  output logic                push_o,
  output cmd_t                cmd_o,
  output logic [N_W-1:0]      eff_len_o
);

  logic             built_q, built_d;
  logic [N_W-1:0]   eff_len;
  logic [POS_W-1:0] width;
  logic [LVL_W-1:0] lvl;
  logic             accept;

  always_comb begin
    eff_len = (int'(length_i) > MAX_ELEMENTS) ? N_W'(MAX_ELEMENTS) : N_W'(length_i);
    width   = in_i.right - {1'b0, in_i.left};
    // Floor log2 of the range width: the highest set bit wins.
    lvl = '0;
    for (int i = 0; i < POS_W; i++) begin
      if (width[i]) lvl = LVL_W'(i);
    end
  end

  always_comb begin
    accept  = start_i && !q_full_i;
    built_d = built_q;
    push_o  = 1'b0;
    cmd_o   = '0;
    if (accept) begin
      unique case (in_i.action)
        ACT_LOAD: begin
          built_d = 1'b0;
          if (int'(in_i.index) < MAX_ELEMENTS) begin
            push_o      = 1'b1;
            cmd_o.kind  = CMD_LOAD;
            cmd_o.pos_a = POS_W'(in_i.index);
            cmd_o.value = $unsigned(in_i.value);
          end
        end
        ACT_BUILD: begin
          built_d    = 1'b1;
          push_o     = 1'b1;
          cmd_o.kind = CMD_BUILD;
        end
        ACT_QUERY: begin
          push_o = 1'b1;
          priority if (!built_q) begin
            cmd_o.kind   = CMD_REPORT;
            cmd_o.status = STS_NOT_BUILT;
          end else if (({1'b0, in_i.left} >= in_i.right) ||
                       (int'(in_i.right) > int'(eff_len)) ||
                       (int'(lvl) >= LEVELS)) begin
            cmd_o.kind   = CMD_REPORT;
            cmd_o.status = STS_BAD_RANGE;
          end else begin
            cmd_o.kind   = CMD_QUERY;
            cmd_o.status = STS_ANSWER;
            cmd_o.lvl    = lvl;
            cmd_o.pos_a  = {1'b0, in_i.left};
            cmd_o.pos_b  = in_i.right - (POS_W'(1) << lvl);
          end
        end
        ACT_NONE: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      built_q <= 1'b0;
    end else begin
      built_q <= built_d;
    end
  end

  assign eff_len_o = eff_len;

endmodule

### rtl/strm_queue.sv
// ----------------------------------------------------------------------------
// Sparse table range minimum: command queue
// Short FIFO of classified items between the front and the back.
// ----------------------------------------------------------------------------
module strm_queue import strm_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  input  logic pop_i,
  output logic full_o,
  output logic empty_o,
  output cmd_t head_o
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             slot_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [CNT_W-1:0] cnt_q;

  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wr_q] <= cmd_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= (wr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
      if (pop_i)  rd_q <= (rd_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
      unique case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  assign full_o  = (cnt_q == CNT_W'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = slot_q[rd_q];

endmodule

### rtl/strm_back.sv
// ----------------------------------------------------------------------------
// Sparse table range minimum: back end
// Owns the level store. Executes loads, runs the build sequencer and answers
// queries through a read stage and a combine stage.
// ----------------------------------------------------------------------------
module strm_back import strm_pkg::*; #(
  parameter int  MAX_ELEMENTS = MAX_ELEMENTS_DEF,
  parameter int  LEVELS       = LEVELS_DEF,
  parameter int  DATA_WIDTH   = DATA_WIDTH_DEF,
  localparam int N_W          = $clog2(MAX_ELEMENTS + 1)
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           mode_i,
  input  logic [N_W-1:0] n_i,
  input  logic           empty_i,
  input  cmd_t           head_i,
  output logic           pop_o,
  output logic           res_valid_o,
  output strm_out_t      res_o
);

  localparam int K_W = $clog2(LEVELS);
  localparam int J_W = $clog2(MAX_ELEMENTS);
  localparam int A_W = $clog2(LEVELS * MAX_ELEMENTS);

  typedef enum logic [1:0] {S_IDLE, S_BUILD, S_GAP} state_e;
  typedef enum logic [1:0] {OP_NONE, OP_ANSWER, OP_WRITE, OP_REPORT} op_e;

  logic [DATA_WIDTH-1:0] mem [LEVELS * MAX_ELEMENTS];
  logic [DATA_WIDTH-1:0] rd_a_q, rd_b_q, pick, wd;
  logic [A_W-1:0]        ra, rb, wa;
  logic                  we;

  state_e         state_q, state_d;
  op_e            op_q, op_d;
  logic [K_W-1:0] k_q, k_d;
  logic [J_W-1:0] j_q, j_d;
  logic [A_W-1:0] waddr_q, waddr_d;
  status_e        sts_q, sts_d;
  logic           res_valid_q;
  strm_out_t      res_q, res_d;

  logic [A_W-1:0] base_lo, base_hi;
  logic [N_W-1:0] half, last;
  logic           next_ok;

  // Two read ports and one write port, read data registered.
  always_ff @(posedge clk_i) begin
    if (we) mem[wa] <= wd;
    rd_a_q <= mem[ra];
    rd_b_q <= mem[rb];
  end

  always_comb begin
    if (mode_i) begin
      pick = ($signed(rd_b_q) > $signed(rd_a_q)) ? rd_b_q : rd_a_q;
    end else begin
      pick = ($signed(rd_b_q) < $signed(rd_a_q)) ? rd_b_q : rd_a_q;
    end
  end

  // A build write and a load never meet: loads are only taken in the idle state.
  always_comb begin
    we = 1'b0;
    wa = waddr_q;
    wd = pick;
    priority if (op_q == OP_WRITE) begin
      we = 1'b1;
    end else if (pop_o && head_i.kind == CMD_LOAD) begin
      we = 1'b1;
      wa = A_W'(head_i.pos_a);
      wd = DATA_WIDTH'(head_i.value);
    end
  end

  always_comb begin
    base_lo = A_W'(k_q - 1'b1) * A_W'(MAX_ELEMENTS);
    base_hi = A_W'(k_q) * A_W'(MAX_ELEMENTS);
    half    = N_W'(1) << (k_q - 1'b1);
    last    = n_i - (N_W'(1) << k_q);
    next_ok = (int'(k_q) + 1 < LEVELS) && ((n_i >> (k_q + 1'b1)) != '0);
  end

  always_comb begin
    state_d = state_q;
    k_d     = k_q;
    j_d     = j_q;
    op_d    = OP_NONE;
    waddr_d = waddr_q;
    sts_d   = sts_q;
    pop_o   = 1'b0;
    ra      = '0;
    rb      = '0;
    unique case (state_q)
      S_IDLE: begin
        if (!empty_i) begin
          pop_o = 1'b1;
          unique case (head_i.kind)
            CMD_LOAD: ;
            CMD_QUERY: begin
              ra   = A_W'(head_i.lvl) * A_W'(MAX_ELEMENTS) + A_W'(head_i.pos_a);
              rb   = A_W'(head_i.lvl) * A_W'(MAX_ELEMENTS) + A_W'(head_i.pos_b);
              op_d = OP_ANSWER;
            end
            CMD_REPORT: begin
              op_d  = OP_REPORT;
              sts_d = head_i.status;
            end
            CMD_BUILD: begin
              if ((n_i >> 1) != '0) begin
                state_d = S_BUILD;
                k_d     = K_W'(1);
                j_d     = '0;
              end else begin
                op_d  = OP_REPORT;
                sts_d = STS_BUILT;
              end
            end
          endcase
        end
      end
      S_BUILD: begin
        ra      = base_lo + A_W'(j_q);
        rb      = base_lo + A_W'(j_q) + A_W'(half);
        op_d    = OP_WRITE;
        waddr_d = base_hi + A_W'(j_q);
        if (N_W'(j_q) == last) begin
          state_d = S_GAP;
        end else begin
          j_d = j_q + 1'b1;
        end
      end
      S_GAP: begin
        // The quiet gap state lets the last write of a level land before it is read.
        if (next_ok) begin
          state_d = S_BUILD;
          k_d     = k_q + 1'b1;
          j_d     = '0;
        end else begin
          state_d = S_IDLE;
          op_d    = OP_REPORT;
          sts_d   = STS_BUILT;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    res_d        = '0;
    res_d.status = sts_q;
    if (op_q == OP_ANSWER) begin
      res_d.answer = 32'($signed(pick));
      res_d.status = STS_ANSWER;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= OP_NONE;
      k_q         <= '0;
      j_q         <= '0;
      waddr_q     <= '0;
      sts_q       <= STS_ANSWER;
      res_valid_q <= 1'b0;
      res_q       <= '0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      k_q         <= k_d;
      j_q         <= j_d;
      waddr_q     <= waddr_d;
      sts_q       <= sts_d;
      res_valid_q <= (op_q == OP_ANSWER) || (op_q == OP_REPORT);
      res_q       <= res_d;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

### rtl/sparse_table_range_min.sv
// ----------------------------------------------------------------------------
// Sparse table range minimum: top level
// Sparse table for minimum or maximum range queries over loaded elements.
//
//   channel  handshake                   payload
//   input    start_i, busy_o             in_i (action, index, value, left, right)
//   result   res_valid_o (one cycle)     res_o (answer, status)
//   config   cfg_valid_i, cfg_ready_o    cfg_index_i, cfg_data_i
//
// Loads and queries each pass through the back end without holding it, so
// items stream at one per cycle while no build runs; a query result passes
// the queue, the read stage and the result register. A build holds the back
// end while it fills each level through the single write port of the level
// store; busy_o rises once the two-entry queue fills behind it. Reset clears
// the built mark and the queue and sets the length to 1024 and the mode to
// min; the level store is not cleared. Results cannot be stalled.
// ----------------------------------------------------------------------------
`include "sparse_table_range_min_macros.svh"

module sparse_table_range_min import strm_pkg::*; #(
  parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF,
  parameter int LEVELS       = LEVELS_DEF,
  parameter int DATA_WIDTH   = DATA_WIDTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  strm_in_t            in_i,
  output logic                res_valid_o,
  output strm_out_t           res_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  cfg_index_e          cfg_index_i,
  input  logic [LENGTH_W-1:0] cfg_data_i
);

  localparam int N_W = $clog2(MAX_ELEMENTS + 1);

  logic [LENGTH_W-1:0] length_q;
  logic                mode_q;
  logic                q_push, q_pop, q_full, q_empty;
  cmd_t                q_in, q_head;
  logic [N_W-1:0]      eff_len;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      length_q <= LENGTH_W'(1024);
      mode_q   <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_LENGTH: length_q <= cfg_data_i;
        CFG_MODE:   mode_q   <= cfg_data_i[0];
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;
  assign busy_o      = q_full;

  strm_front #(
    .MAX_ELEMENTS(MAX_ELEMENTS),
    .LEVELS      (LEVELS)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .in_i     (in_i),
    .length_i (length_q),
    .q_full_i (q_full),
    .push_o   (q_push),
    .cmd_o    (q_in),
    .eff_len_o(eff_len)
  );

  strm_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .cmd_i  (q_in),
    .pop_i  (q_pop),
    .full_o (q_full),
    .empty_o(q_empty),
    .head_o (q_head)
  );

  strm_back #(
    .MAX_ELEMENTS(MAX_ELEMENTS),
    .LEVELS      (LEVELS),
    .DATA_WIDTH  (DATA_WIDTH)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .mode_i     (mode_q),
    .n_i        (eff_len),
    .empty_i    (q_empty),
    .head_i     (q_head),
    .pop_o      (q_pop),
    .res_valid_o(res_valid_o),
    .res_o      (res_o)
  );

  `STRM_ASSERT_HOLDS(a_no_push_when_full, !(q_push && q_full))
  `STRM_ASSERT_HOLDS(a_no_pop_when_empty, !(q_pop && q_empty))
  `STRM_ASSERT_HOLDS(a_zero_answer, !(res_valid_o && res_o.status != STS_ANSWER && |res_o.answer))
  `STRM_ASSERT_NEXT(a_push_fills_queue, q_push && !q_pop, !q_empty)

endmodule

### tb/tb_sparse_table_range_min.sv
// ----------------------------------------------------------------------------
// Sparse table range minimum: testbench
// Loads element arrays, builds the table and runs range queries in min and
// max mode over several array lengths. A local model of the table predicts
// every result, and each result is checked field by field.
// ----------------------------------------------------------------------------
module tb_sparse_table_range_min import strm_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NumLevels = LEVELS_DEF;
  localparam int NumElems  = MAX_ELEMENTS_DEF;

  logic                clk_i;
  logic                rst_ni;
  logic                start_i;
  logic                busy_o;
  strm_in_t            in_i;
  logic                res_valid_o;
  strm_out_t           res_o;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  cfg_index_e          cfg_index_i;
  logic [LENGTH_W-1:0] cfg_data_i;

  // Local copy of the table, its built mark and the two registers.
  logic signed [31:0] level_copy [NumLevels][NumElems];
  bit                 table_built;
  int unsigned        length_reg;
  bit                 mode_max;

  strm_out_t answers_due[$];
  strm_out_t want_res;
  int        mismatches;
  int        gap_pct;

  sparse_table_range_min i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .in_i       (in_i),
    .res_valid_o(res_valid_o),
    .res_o      (res_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5ms;
    $display("DONE: errors detected");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatches < 50) begin
      $display("[%0t] MISMATCH %s: got %0h, expected %0h", $realtime, what, got, want);
    end
    mismatches++;
  endtask

  function automatic logic signed [31:0] combine(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    if (mode_max) begin
      return (b > a) ? b : a;
    end
    return (b < a) ? b : a;
  endfunction

  // Applies one accepted item to the local table and queues its result, if it has one.
  task automatic predict_table_item(input strm_in_t item);
    int unsigned n;
    int unsigned l;
    int unsigned r;
    int unsigned w;
    int          b;
    strm_out_t   res;
    n = (length_reg > NumElems) ? NumElems : length_reg;
    res.answer = '0;
    case (item.action)
      ACT_LOAD: begin
        level_copy[0][item.index] = item.value;
        table_built = 1'b0;
      end
      ACT_BUILD: begin
        for (int k = 1; k < NumLevels && (1 << k) <= n; k++) begin
          for (int j = 0; j + (1 << k) <= n; j++) begin
            level_copy[k][j] = combine(level_copy[k-1][j], level_copy[k-1][j + (1 << (k-1))]);
          end
        end
        table_built = 1'b1;
        res.status = STS_BUILT;
        answers_due.push_back(res);
      end
      ACT_QUERY: begin
        l = item.left;
        r = item.right;
        if (!table_built) begin
          res.status = STS_NOT_BUILT;
        end else if (l >= r || r > n) begin
          res.status = STS_BAD_RANGE;
        end else begin
          w = r - l;
          b = 0;
          while (w > 1) begin
            w = w >> 1;
            b++;
          end
          if (b >= NumLevels) begin
            res.status = STS_BAD_RANGE;
          end else begin
            res.status = STS_ANSWER;
            res.answer = combine(level_copy[b][l], level_copy[b][r - (1 << b)]);
          end
        end
        answers_due.push_back(res);
      end
      default: begin
      end
    endcase
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && $isunknown(res_valid_o)) begin
      report_mismatch("result strobe unknown", 32'(res_valid_o), '0);
    end else if (rst_ni && res_valid_o) begin
      if (answers_due.size() == 0) begin
        report_mismatch("result with nothing pending", res_o.answer, '0);
      end else begin
        want_res = answers_due.pop_front();
        if (res_o.status !== want_res.status) begin
          report_mismatch("status", 32'(res_o.status), 32'(want_res.status));
        end
        if (res_o.answer !== want_res.answer) begin
          report_mismatch("answer", res_o.answer, want_res.answer);
        end
      end
    end
  end

  function automatic strm_in_t random_item(input action_e act);
    strm_in_t item;
    item.action = act;
    item.index  = 10'($urandom);
    item.value  = $urandom;
    item.left   = 10'($urandom);
    item.right  = 11'($urandom);
    return item;
  endfunction

  task automatic send_item(input strm_in_t item);
    if (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
      repeat ($urandom_range(1, 4)) begin
        @(negedge clk_i);
        start_i <= 1'b0;
      end
    end
    @(negedge clk_i);
    start_i <= 1'b1;
    in_i    <= item;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    predict_table_item(item);
  endtask

  task automatic send_load(input int unsigned idx, input logic signed [31:0] val);
    strm_in_t item;
    item = random_item(ACT_LOAD);
    item.index = 10'(idx);
    item.value = val;
    send_item(item);
  endtask

  task automatic send_query(input int unsigned l, input int unsigned r);
    strm_in_t item;
    item = random_item(ACT_QUERY);
    item.left  = 10'(l);
    item.right = 11'(r);
    send_item(item);
  endtask

  // Stops sending and waits until every expected result has arrived, then lets
  // the trailing loads drain out of the block.
  task automatic wait_results;
    @(negedge clk_i);
    start_i <= 1'b0;
    while (answers_due.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_register(input cfg_index_e idx, input logic [LENGTH_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    if (idx == CFG_LENGTH) begin
      length_reg = data;
    end else begin
      mode_max = data[0];
    end
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic test_query_before_build;
    send_query(0, 1);
    send_item(random_item(ACT_NONE));
    // The built mark is checked before the range, so this is not a bad range.
    send_query(5, 2);
  endtask

  task automatic test_min_extremes;
    logic signed [31:0] vals [8];
    vals = '{32'sh7FFFFFFF, 32'sh80000000, -32'sd1, 32'sd0, 32'sd1, 32'sd12345,
             -32'sd54321, 32'sh7FFFFFFE};
    wait_results();
    write_register(CFG_LENGTH, 11'd8);
    write_register(CFG_MODE, 11'd0);
    foreach (vals[i]) send_load(i, vals[i]);
    // A load beyond the length still writes and still clears the built mark.
    send_load(1023, 32'sh5A5A5A5A);
    send_item(random_item(ACT_BUILD));
    send_query(0, 8);
    send_query(2, 3);
    send_query(3, 8);
    send_query(0, 1);
  endtask

  task automatic test_bad_ranges;
    send_query(4, 4);
    send_query(6, 2);
    send_query(0, 9);
    send_query(1023, 2047);
  endtask

  task automatic test_max_mode;
    wait_results();
    write_register(CFG_MODE, 11'h3FF);
    // The table still holds minimums here; only the final combine uses max.
    send_query(1, 5);
    send_item(random_item(ACT_BUILD));
    send_query(0, 8);
    send_query(1, 3);
    send_query(7, 8);
  endtask

  task automatic run_table_phase(input int unsigned n, input bit use_max,
                                 input int pct, input int traffic);
    int unsigned roll;
    int unsigned l;
    strm_in_t    item;
    wait_results();
    write_register(CFG_LENGTH, 11'(n));
    write_register(CFG_MODE, {10'($urandom), use_max});
    gap_pct = pct;
    for (int i = 0; i < n; i++) send_load(i, $urandom);
    send_item(random_item(ACT_BUILD));
    for (int i = 0; i < traffic; i++) begin
      roll = $urandom_range(99);
      if ($urandom_range(99) < 2) begin
        wait_results();
      end
      if (roll < 14) begin
        item = random_item(ACT_LOAD);
        if ($urandom_range(4) != 0) item.index = 10'($urandom_range(n - 1));
        send_item(item);
      end else if (roll < 20 && n <= 128) begin
        send_item(random_item(ACT_BUILD));
      end else if (roll < 26) begin
        send_item(random_item(ACT_QUERY));
      end else if (roll < 28) begin
        send_item(random_item(ACT_NONE));
      end else begin
        l = $urandom_range(n - 1);
        send_query(l, $urandom_range(n, l + 1));
      end
    end
  endtask

  task automatic test_random_tables;
    int unsigned sizes [12];
    sizes[0] = 1;
    sizes[1] = 2;
    sizes[2] = 3;
    sizes[3] = 1024;
    sizes[4] = 64;
    for (int i = 5; i < 12; i++) sizes[i] = $urandom_range(4, 64);
    foreach (sizes[i]) begin
      run_table_phase(sizes[i], i[0], (i % 3 == 1) ? 67 : ((i % 3 == 2) ? 23 : 0),
                      (sizes[i] > 128) ? 100 : 50);
    end
  endtask

  initial begin
    rst_ni      = 1'b0;
    start_i     = 1'b0;
    in_i        = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CFG_LENGTH;
    cfg_data_i  = '0;
    table_built = 1'b0;
    length_reg  = NumElems;
    mode_max    = 1'b0;
    mismatches  = 0;
    gap_pct     = 0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;

    test_query_before_build();
    test_min_extremes();
    test_bad_ranges();
    test_max_mode();
    test_random_tables();

    wait_results();
    if (answers_due.size() != 0) begin
      report_mismatch("results never arrived", answers_due.size(), '0);
    end
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

### sparse_table_range_min.f
+incdir+rtl
rtl/strm_pkg.sv
rtl/strm_front.sv
rtl/strm_queue.sv
rtl/strm_back.sv
rtl/sparse_table_range_min.sv
tb/tb_sparse_table_range_min.sv
